/* hdl/dmbd_pkg.sv */
// shared types, constants and helpers of the min-depth bin downsampler
// no dependencies
`default_nettype none

package dmbd_pkg;

    localparam int DEPTH_W       = 16;
    localparam int CELL_W        = 8;
    localparam int CFG_W         = 12;
    localparam int DST_CFG_W     = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int DST_ROW_LIMIT = 256;
    localparam int FIFO_DEPTH    = 3;

    localparam logic [CFG_W-1:0]     SRC_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]     SRC_HEIGHT_RST = 12'd480;
    localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 9'd160;
    localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 9'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_sample;
        logic               frame_start;
    } t_in_item;

    typedef struct packed {
        logic [DEPTH_W-1:0] min_depth;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
        logic               frame_done;
    } t_out_item;

    typedef struct packed {
        logic [DEPTH_W-1:0] run_min;
        logic               row_first;
        logic               row_last;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
        logic               frame_done;
    } t_bin_evt;

    // zero means no valid depth
    function automatic logic [DEPTH_W-1:0] merge_min(input logic [DEPTH_W-1:0] a,
                                                     input logic [DEPTH_W-1:0] b);
        if (a == '0) begin
            return b;
        end else if (b == '0) begin
            return a;
        end else begin
            return (a < b) ? a : b;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/dmbd_line_store.sv */
// line store of partial bin minima, one entry per output column
// registered read with write-to-read forwarding; uses dmbd_pkg
`default_nettype none

module dmbd_line_store #(
    parameter int IDX_W = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic [IDX_W-1:0]            i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [IDX_W-1:0]            i_wr_addr,
    input  wire logic [dmbd_pkg::DEPTH_W-1:0] i_wr_data,
    output logic      [dmbd_pkg::DEPTH_W-1:0] o_rd_data
);

    logic [dmbd_pkg::DEPTH_W-1:0] r_mem [DEPTH];
    logic [dmbd_pkg::DEPTH_W-1:0] r_q;
    logic [dmbd_pkg::DEPTH_W-1:0] r_fwd_data;
    logic                         r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

/* hdl/dmbd_bin_track.sv */
// configuration registers, position counters, bin error accumulators, running minimum
// issues one bin event per finished column bin; uses dmbd_pkg
`default_nettype none

module dmbd_bin_track #(
    parameter int MAX_SRC_SIZE  = 2048,
    parameter int MAX_DST_WIDTH = 256,
    localparam int IDX_W = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dmbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dmbd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_accept,
    input  wire dmbd_pkg::t_in_item            i_item,
    output logic                               o_evt_valid,
    output dmbd_pkg::t_bin_evt                 o_evt,
    output logic      [IDX_W-1:0]              o_idx
);

    localparam int SZ_W = $clog2(MAX_SRC_SIZE + 1);
    localparam int CW   = $clog2(MAX_SRC_SIZE);
    localparam int XW   = (SZ_W > dmbd_pkg::CFG_W) ? SZ_W : dmbd_pkg::CFG_W;
    localparam int AW   = XW + 1;

    function automatic logic [SZ_W-1:0] clamp_src(input logic [dmbd_pkg::CFG_W-1:0] raw);
        logic [XW-1:0] v;
        v = XW'(raw);
        if (v == '0) begin
            return SZ_W'(1);
        end else if (v > XW'(MAX_SRC_SIZE)) begin
            return SZ_W'(MAX_SRC_SIZE);
        end else begin
            return v[SZ_W-1:0];
        end
    endfunction

    function automatic logic [SZ_W-1:0] clamp_dst(input logic [dmbd_pkg::DST_CFG_W-1:0] raw,
                                                  input logic [SZ_W-1:0] sz,
                                                  input int unsigned lim);
        logic [XW-1:0] v;
        logic [XW-1:0] hi;
        v  = XW'(raw);
        hi = (XW'(sz) < XW'(lim)) ? XW'(sz) : XW'(lim);
        if (v == '0) begin
            return SZ_W'(1);
        end else if (v > hi) begin
            return hi[SZ_W-1:0];
        end else begin
            return v[SZ_W-1:0];
        end
    endfunction

    logic [dmbd_pkg::CFG_W-1:0]     r_src_w, r_src_h;
    logic [dmbd_pkg::DST_CFG_W-1:0] r_dst_w, r_dst_h;
    logic [SZ_W-1:0]                r_sw, r_sh, r_dw, r_dh;
    logic [SZ_W-1:0]                n_sw, n_sh, n_dw, n_dh;

    logic [CW-1:0] r_in_col, r_in_row, r_bin_col, r_bin_row, r_col_err, r_row_err;
    logic [CW-1:0] n_in_col, n_in_row, n_bin_col, n_bin_row, n_col_err, n_row_err;
    logic [dmbd_pkg::DEPTH_W-1:0] r_run_min, n_run_min;

    logic [CW-1:0] e_in_col, e_in_row, e_bin_col, e_bin_row, e_col_err, e_row_err;
    logic [dmbd_pkg::DEPTH_W-1:0] e_run_min, rm;
    logic [AW-1:0] col_sum, row_sum;
    logic          row_end, frame_end, col_last, row_last, row_first;

    assign n_sw = clamp_src(r_src_w);
    assign n_sh = clamp_src(r_src_h);
    assign n_dw = clamp_dst(r_dst_w, n_sw, MAX_DST_WIDTH);
    assign n_dh = clamp_dst(r_dst_h, n_sh, dmbd_pkg::DST_ROW_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= dmbd_pkg::SRC_WIDTH_RST;
            r_src_h <= dmbd_pkg::SRC_HEIGHT_RST;
            r_dst_w <= dmbd_pkg::DST_WIDTH_RST;
            r_dst_h <= dmbd_pkg::DST_HEIGHT_RST;
            r_sw    <= clamp_src(dmbd_pkg::SRC_WIDTH_RST);
            r_sh    <= clamp_src(dmbd_pkg::SRC_HEIGHT_RST);
            r_dw    <= clamp_dst(dmbd_pkg::DST_WIDTH_RST,
                                 clamp_src(dmbd_pkg::SRC_WIDTH_RST), MAX_DST_WIDTH);
            r_dh    <= clamp_dst(dmbd_pkg::DST_HEIGHT_RST,
                                 clamp_src(dmbd_pkg::SRC_HEIGHT_RST), dmbd_pkg::DST_ROW_LIMIT);
        end else begin
            if (i_cfg_we) begin
                unique case (dmbd_pkg::t_reg_idx'(i_cfg_idx))
                    dmbd_pkg::REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                    dmbd_pkg::REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                    dmbd_pkg::REG_DST_WIDTH:  r_dst_w <= i_cfg_data[dmbd_pkg::DST_CFG_W-1:0];
                    dmbd_pkg::REG_DST_HEIGHT: r_dst_h <= i_cfg_data[dmbd_pkg::DST_CFG_W-1:0];
                    default: ;
                endcase
            end
            r_sw <= n_sw;
            r_sh <= n_sh;
            r_dw <= n_dw;
            r_dh <= n_dh;
        end
    end

    always_comb begin
        // frame start restarts the position before the sample is counted
        e_in_col  = i_item.frame_start ? '0 : r_in_col;
        e_in_row  = i_item.frame_start ? '0 : r_in_row;
        e_bin_col = i_item.frame_start ? '0 : r_bin_col;
        e_bin_row = i_item.frame_start ? '0 : r_bin_row;
        e_col_err = i_item.frame_start ? '0 : r_col_err;
        e_row_err = i_item.frame_start ? '0 : r_row_err;
        e_run_min = i_item.frame_start ? '0 : r_run_min;

        rm        = dmbd_pkg::merge_min(e_run_min, i_item.depth_sample);
        col_sum   = AW'(e_col_err) + AW'(r_dw);
        row_sum   = AW'(e_row_err) + AW'(r_dh);
        row_end   = (AW'(e_in_col) + AW'(1)) >= AW'(r_sw);
        frame_end = (AW'(e_in_row) + AW'(1)) >= AW'(r_sh);
        col_last  = row_end || (col_sum >= AW'(r_sw));
        row_last  = frame_end || (row_sum >= AW'(r_sh));
        row_first = AW'(e_row_err) < AW'(r_dh);

        n_in_col  = e_in_col;
        n_in_row  = e_in_row;
        n_bin_col = e_bin_col;
        n_bin_row = e_bin_row;
        n_col_err = e_col_err;
        n_row_err = e_row_err;
        n_run_min = col_last ? '0 : rm;

        if (row_end) begin
            n_in_col  = '0;
            n_col_err = '0;
            n_bin_col = '0;
            if (frame_end) begin
                n_in_row  = '0;
                n_row_err = '0;
                n_bin_row = '0;
            end else begin
                n_in_row = e_in_row + CW'(1);
                if (row_sum >= AW'(r_sh)) begin
                    n_row_err = CW'(row_sum - AW'(r_sh));
                    n_bin_row = e_bin_row + CW'(1);
                end else begin
                    n_row_err = CW'(row_sum);
                end
            end
        end else begin
            n_in_col = e_in_col + CW'(1);
            if (col_sum >= AW'(r_sw)) begin
                n_col_err = CW'(col_sum - AW'(r_sw));
                n_bin_col = e_bin_col + CW'(1);
            end else begin
                n_col_err = CW'(col_sum);
            end
        end

        o_evt_valid      = i_accept && col_last;
        o_evt.run_min    = rm;
        o_evt.row_first  = row_first;
        o_evt.row_last   = row_last;
        o_evt.cell_col   = dmbd_pkg::CELL_W'(e_bin_col);
        o_evt.cell_row   = dmbd_pkg::CELL_W'(e_bin_row);
        o_evt.frame_done = row_end && frame_end;

        if (AW'(e_bin_col) >= AW'(MAX_DST_WIDTH)) begin
            o_idx = IDX_W'(MAX_DST_WIDTH - 1);
        end else begin
            o_idx = IDX_W'(e_bin_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_bin_col <= '0;
            r_bin_row <= '0;
            r_col_err <= '0;
            r_row_err <= '0;
            r_run_min <= '0;
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_bin_col <= n_bin_col;
            r_bin_row <= n_bin_row;
            r_col_err <= n_col_err;
            r_row_err <= n_row_err;
            r_run_min <= n_run_min;
        end
    end

endmodule

`default_nettype wire

/* hdl/dmbd_out_fifo.sv */
// three-entry result queue between the merge stage and the output channel
// uses dmbd_pkg
`default_nettype none

module dmbd_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dmbd_pkg::t_out_item i_data,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output dmbd_pkg::t_out_item     o_data,
    output logic [1:0]              o_count
);

    dmbd_pkg::t_out_item r_mem [dmbd_pkg::FIFO_DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr, r_count;
    logic       pop;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(dmbd_pkg::FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

/* hdl/depth_min_bin_downsample.sv */
// top level of the min-depth bin downsampler: merge stage and channel control
// uses dmbd_pkg, dmbd_bin_track, dmbd_line_store, dmbd_out_fifo
//
// Depth samples enter in raster order on the input channel (valid/ready), one
// transaction per pixel; frame_start on a sample restarts the position. Each
// output transaction is one finished cell: the smallest nonzero depth of its
// bin (0 if none), its column and row, and frame_done on the last cell.
// Throughput: one sample per cycle while o_in_ready is high. The sample is classified in
// the first stage, which reads the line store; the merge and the write-back
// or output happen in the second. A finished cell is pushed into the result
// queue from the second stage.
// Results wait in a three-entry queue; o_in_ready falls when the queue and the
// merge stage together hold three results, so a stalled receiver stops the
// input without loss. The input also pauses in the cycle after a register
// write while the clamped sizes settle.
// Reset clears the position counters and the queue and loads the register
// defaults (640x480 to 160x120); the line store is not cleared, since an
// entry is only read after the first row of its bin row has written it.
`default_nettype none

module depth_min_bin_downsample #(
    parameter int MAX_SRC_SIZE  = 2048,
    parameter int MAX_DST_WIDTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dmbd_pkg::t_in_item            i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dmbd_pkg::t_out_item                o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [dmbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dmbd_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;

    logic                         in_accept;
    logic                         evt_valid;
    dmbd_pkg::t_bin_evt           evt;
    logic [IDX_W-1:0]             evt_idx;

    logic                         r_s1_valid;
    dmbd_pkg::t_bin_evt           r_s1_evt;
    logic [IDX_W-1:0]             r_s1_idx;
    logic                         r_cfg_settle;

    logic [dmbd_pkg::DEPTH_W-1:0] store_q;
    logic [dmbd_pkg::DEPTH_W-1:0] merged;
    logic                         s1_write, s1_push;
    dmbd_pkg::t_out_item          s1_item;
    logic [1:0]                   fifo_count;

    assign in_accept = i_in_valid && o_in_ready;

    dmbd_bin_track #(
        .MAX_SRC_SIZE  (MAX_SRC_SIZE),
        .MAX_DST_WIDTH (MAX_DST_WIDTH)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_item      (i_in),
        .o_evt_valid (evt_valid),
        .o_evt       (evt),
        .o_idx       (evt_idx)
    );

    dmbd_line_store #(
        .IDX_W (IDX_W),
        .DEPTH (MAX_DST_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (evt_valid && !evt.row_first),
        .i_rd_addr (evt_idx),
        .i_wr_en   (s1_write),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (merged),
        .o_rd_data (store_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_cfg_settle <= 1'b0;
        end else begin
            r_s1_valid   <= evt_valid;
            r_cfg_settle <= i_cfg_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_valid) begin
            r_s1_evt <= evt;
            r_s1_idx <= evt_idx;
        end
    end

    always_comb begin
        merged = r_s1_evt.row_first ? r_s1_evt.run_min
                                    : dmbd_pkg::merge_min(r_s1_evt.run_min, store_q);
        s1_write = r_s1_valid && !r_s1_evt.row_last;
        s1_push  = r_s1_valid && r_s1_evt.row_last;
        s1_item.min_depth  = merged;
        s1_item.cell_col   = r_s1_evt.cell_col;
        s1_item.cell_row   = r_s1_evt.cell_row;
        s1_item.frame_done = r_s1_evt.frame_done;
    end

    dmbd_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_push),
        .i_data  (s1_item),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .o_count (fifo_count)
    );

    // room for the result that may still be in the merge stage
    assign o_in_ready = ((3'(fifo_count) + 3'(s1_push)) < 3'(dmbd_pkg::FIFO_DEPTH))
                        && !r_cfg_settle;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_push && (fifo_count == 2'(dmbd_pkg::FIFO_DEPTH))))
        else $error("result queue overflow");

    a_s1_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(in_accept))
        else $error("merge stage busy without an input transaction");

    a_no_accept_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !in_accept)
        else $error("sample taken before clamped sizes settled");

endmodule

`default_nettype wire
